>>> rtl/bpa_pkg.sv
// bpa_pkg: constants, opcodes and shared structs for the bitmap page allocator
// no dependencies; used by the interfaces and all rtl modules
package bpa_pkg;

  localparam int unsigned BITMAP_BYTES = 512;
  localparam int unsigned BYTE_AW      = $clog2(BITMAP_BYTES);
  localparam int unsigned BIT_W        = 3;
  localparam int unsigned PAGE_W       = 12;
  localparam int unsigned CFG_W        = 10;
  localparam int unsigned OP_W         = 2;

  localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0]       BYTE_FULL  = 8'hff;
  localparam logic [7:0]       BYTE_EMPTY = 8'h00;
  localparam logic [CFG_W-1:0] LIMIT_MAX  = CFG_W'(BITMAP_BYTES);

  typedef struct packed {
    logic               wr_en;
    logic [BYTE_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [BYTE_AW-1:0] rd_addr;
  } mem_cmd_t;

  typedef struct packed {
    logic             full;
    logic [BIT_W-1:0] low_bit;
    logic [7:0]       set_byte;
    logic [7:0]       clr_byte;
  } scan_res_t;

endpackage

>>> rtl/bpa_if.sv
// bpa_if: valid/ready channel interfaces for request, response and config words
// depends on bpa_pkg
interface bpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bpa_pkg::OP_W-1:0]    opcode;
  logic [bpa_pkg::PAGE_W-1:0]  page_number;
  modport source (output valid, opcode, page_number, input ready);
  modport sink (input valid, opcode, page_number, output ready);
endinterface

interface bpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [bpa_pkg::PAGE_W-1:0]  free_page;
  modport source (output valid, found, free_page, input ready);
  modport sink (input valid, found, free_page, output ready);
endinterface

interface bpa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bpa_pkg::CFG_W-1:0]   bytes_in_use;
  modport source (output valid, bytes_in_use, input ready);
  modport sink (input valid, bytes_in_use, output ready);
endinterface

>>> rtl/bpa_bitmap_ram.sv
// bpa_bitmap_ram: usage bitmap storage, one write and one registered read port
// depends on bpa_pkg
module bpa_bitmap_ram (
  input  logic               clk,
  input  bpa_pkg::mem_cmd_t  cmd,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [bpa_pkg::BITMAP_BYTES];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

endmodule

>>> rtl/bpa_scan_unit.sv
// bpa_scan_unit: shared byte unit, full test, lowest clear bit, bit set and clear
// depends on bpa_pkg
module bpa_scan_unit (
  input  logic [7:0]                 data,
  input  logic [bpa_pkg::BIT_W-1:0]  bit_sel,
  output bpa_pkg::scan_res_t         res
);

  logic [7:0]                 mask;
  logic [bpa_pkg::BIT_W-1:0]  low;

  always_comb begin
    low = '0;
    for (int i = 7; i >= 0; i--) begin
      if (!data[i]) begin
        low = bpa_pkg::BIT_W'(i);
      end
    end
  end

  assign mask         = 8'(1) << bit_sel;
  assign res.full     = (data == bpa_pkg::BYTE_FULL);
  assign res.low_bit  = low;
  assign res.set_byte = data | mask;
  assign res.clr_byte = data & ~mask;

endmodule

>>> rtl/bitmap_page_allocator.sv
// bitmap_page_allocator: next-fit page allocator over a byte-wide usage bitmap
// depends on bpa_pkg, bpa_if, bpa_bitmap_ram, bpa_scan_unit
//
//   channel  dir  word                      handshake
//   req      in   opcode, page_number       valid/ready
//   rsp      out  found, free_page          valid/ready
//   cfg      in   bytes_in_use              valid/ready, always ready
//
// after reset the bitmap is wiped one byte a cycle, all 512 bytes, req not ready
// find: scans from the hint up to the limit, one byte per cycle through the ram read port
// set, clear: accept, ram read, modify and write, rsp; unused opcode: accept, rsp
// one request in flight; req is ready again once the rsp word is taken
module bitmap_page_allocator (
  input  logic          clk,
  input  logic          rst,
  bpa_req_if.sink       req,
  bpa_rsp_if.source     rsp,
  bpa_cfg_if.sink       cfg
);

  typedef enum logic [2:0] {
    S_WIPE, S_IDLE, S_FIND, S_RD, S_WR, S_OUT
  } state_t;

  state_t                           state;
  logic [bpa_pkg::BYTE_AW-1:0]      wipe_cnt;
  logic [bpa_pkg::BYTE_AW-1:0]      hint;
  logic [bpa_pkg::CFG_W-1:0]        bytes_in_use;
  logic [bpa_pkg::CFG_W-1:0]        scan_addr;
  logic                             chk_valid;
  logic [bpa_pkg::BYTE_AW-1:0]      chk_addr;
  logic [bpa_pkg::OP_W-1:0]         op;
  logic [bpa_pkg::BYTE_AW-1:0]      op_byte;
  logic [bpa_pkg::BIT_W-1:0]        op_bit;
  logic                             found;
  logic [bpa_pkg::PAGE_W-1:0]       free_page;

  logic [bpa_pkg::CFG_W-1:0]        limit;
  logic                             scan_live;
  bpa_pkg::mem_cmd_t                mem_cmd;
  logic [7:0]                       rd_data;
  bpa_pkg::scan_res_t               scan;

  assign limit     = (bytes_in_use > bpa_pkg::LIMIT_MAX) ? bpa_pkg::LIMIT_MAX : bytes_in_use;
  assign scan_live = (scan_addr < limit);

  always_comb begin
    mem_cmd.wr_en   = (state == S_WIPE) || (state == S_WR);
    mem_cmd.wr_addr = (state == S_WIPE) ? wipe_cnt : op_byte;
    if (state == S_WIPE) begin
      mem_cmd.wr_data = bpa_pkg::BYTE_EMPTY;
    end else if (op == bpa_pkg::OP_SET) begin
      mem_cmd.wr_data = scan.set_byte;
    end else begin
      mem_cmd.wr_data = scan.clr_byte;
    end
    mem_cmd.rd_en   = ((state == S_FIND) && scan_live) || (state == S_RD);
    mem_cmd.rd_addr = (state == S_FIND) ? scan_addr[bpa_pkg::BYTE_AW-1:0] : op_byte;
  end

  bpa_bitmap_ram u_ram (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_data (rd_data)
  );

  bpa_scan_unit u_scan (
    .data    (rd_data),
    .bit_sel (op_bit),
    .res     (scan)
  );

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = (state == S_OUT);
  assign rsp.found     = found;
  assign rsp.free_page = free_page;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WIPE;
      wipe_cnt     <= '0;
      hint         <= '0;
      bytes_in_use <= '0;
      chk_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        bytes_in_use <= cfg.bytes_in_use;
      end
      case (state)
        S_WIPE: begin
          wipe_cnt <= wipe_cnt + 1'b1;
          if (wipe_cnt == bpa_pkg::BYTE_AW'(bpa_pkg::BITMAP_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.opcode;
            op_byte <= req.page_number[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
            op_bit  <= req.page_number[bpa_pkg::BIT_W-1:0];
            if (req.opcode == bpa_pkg::OP_FIND) begin
              scan_addr <= bpa_pkg::CFG_W'(hint);
              chk_valid <= 1'b0;
              state     <= S_FIND;
            end else if (req.opcode == bpa_pkg::OP_SET || req.opcode == bpa_pkg::OP_CLEAR) begin
              state <= S_RD;
            end else begin
              found     <= 1'b0;
              free_page <= '0;
              state     <= S_OUT;
            end
          end
        end
        S_FIND: begin
          if (chk_valid && !scan.full) begin
            found     <= 1'b1;
            free_page <= {chk_addr, scan.low_bit};
            hint      <= chk_addr;
            chk_valid <= 1'b0;
            state     <= S_OUT;
          end else if (!scan_live) begin
            found     <= 1'b0;
            free_page <= '0;
            chk_valid <= 1'b0;
            state     <= S_OUT;
          end else begin
            chk_valid <= 1'b1;
            chk_addr  <= scan_addr[bpa_pkg::BYTE_AW-1:0];
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (op == bpa_pkg::OP_CLEAR) begin
            hint <= op_byte;
          end
          found     <= 1'b0;
          free_page <= '0;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for bitmap_page_allocator, next-fit find, set and clear
// depends on bpa_pkg, bpa_if and the allocator rtl; a directed table then random phases
// under three handshake idle patterns, every response word checked against a typed answer or a local model
module tb_top;

  localparam logic [bpa_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int                       CYCLE_LIMIT = 4000000;
  localparam int                       PRINT_CAP   = 40;

  typedef struct packed {
    logic                       found;
    logic [bpa_pkg::PAGE_W-1:0] free_page;
  } page_answer_t;

  typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [bpa_pkg::OP_W-1:0]   op;
    logic [bpa_pkg::PAGE_W-1:0] page;
    logic [bpa_pkg::CFG_W-1:0]  limit;
    logic                       typed;
    logic                       found;
    logic [bpa_pkg::PAGE_W-1:0] free_page;
  } plan_row_t;

  logic clk;
  logic rst;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();
  bpa_cfg_if cfg_ch ();

  bitmap_page_allocator DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // local copy of the allocator state
  logic [7:0]                  page_map [bpa_pkg::BITMAP_BYTES];
  logic [bpa_pkg::BYTE_AW-1:0] scan_hint;
  logic [bpa_pkg::CFG_W-1:0]   scan_limit;

  page_answer_t pending_answers [$];
  page_answer_t last_answer;
  page_answer_t got_answer;
  page_answer_t want_answer;
  plan_row_t    directed_plan [$];

  int req_idle_pct;
  int rsp_idle_pct;
  int mismatches;
  int cycle_count;
  int finds_hit;
  int finds_missed;
  int sets_done;
  int clears_done;
  int unused_done;
  int limit_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_answers.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
    end
    mismatches++;
  endtask

  function automatic page_answer_t next_fit_step(input logic [bpa_pkg::OP_W-1:0] op,
                                                 input logic [bpa_pkg::PAGE_W-1:0] page);
    page_answer_t ans;
    int lim;
    int b;
    int bit_i;
    int byte_idx;
    ans = '0;
    byte_idx = int'(page >> bpa_pkg::BIT_W);
    case (op)
      bpa_pkg::OP_FIND: begin
        lim = (int'(scan_limit) > int'(bpa_pkg::BITMAP_BYTES)) ?
              int'(bpa_pkg::BITMAP_BYTES) : int'(scan_limit);
        b = int'(scan_hint);
        while (b < lim && !ans.found) begin
          if (page_map[b] != bpa_pkg::BYTE_FULL) begin
            bit_i = 0;
            while (bit_i < 7 && page_map[b][bit_i]) bit_i++;
            scan_hint = bpa_pkg::BYTE_AW'(b);
            ans.found = 1'b1;
            ans.free_page = bpa_pkg::PAGE_W'(b * 8 + bit_i);
          end
          b++;
        end
      end
      bpa_pkg::OP_SET: begin
        if (byte_idx < int'(bpa_pkg::BITMAP_BYTES))
          page_map[byte_idx][page[bpa_pkg::BIT_W-1:0]] = 1'b1;
      end
      bpa_pkg::OP_CLEAR: begin
        if (byte_idx < int'(bpa_pkg::BITMAP_BYTES)) begin
          page_map[byte_idx][page[bpa_pkg::BIT_W-1:0]] = 1'b0;
          scan_hint = bpa_pkg::BYTE_AW'(byte_idx);
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic plan_row_t mk_row(input row_kind_t kind,
                                       input logic [bpa_pkg::OP_W-1:0] op,
                                       input logic [bpa_pkg::PAGE_W-1:0] page,
                                       input logic [bpa_pkg::CFG_W-1:0] limit,
                                       input logic typed, input logic found,
                                       input logic [bpa_pkg::PAGE_W-1:0] fp);
    plan_row_t r;
    r.kind = kind;
    r.op = op;
    r.page = page;
    r.limit = limit;
    r.typed = typed;
    r.found = found;
    r.free_page = fp;
    return r;
  endfunction

  // response side: random stalls and in-order compare
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      got_answer.found = rsp_ch.found;
      got_answer.free_page = rsp_ch.free_page;
      if (pending_answers.size() == 0) begin
        flag_mismatch("unexpected response word, free_page", int'(got_answer.free_page), 0);
      end else begin
        want_answer = pending_answers.pop_front();
        if (got_answer.found !== want_answer.found)
          flag_mismatch("found", int'(got_answer.found), int'(want_answer.found));
        if (got_answer.free_page !== want_answer.free_page)
          flag_mismatch("free_page", int'(got_answer.free_page),
                        int'(want_answer.free_page));
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  task automatic send_word(input logic [bpa_pkg::OP_W-1:0] op,
                           input logic [bpa_pkg::PAGE_W-1:0] page,
                           input logic typed, input page_answer_t typed_ans);
    int gap;
    page_answer_t ans;
    gap = 0;
    while ($urandom_range(99) < req_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.page_number <= page;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ans = next_fit_step(op, page);
    pending_answers.push_back(typed ? typed_ans : ans);
    last_answer = ans;
    case (op)
      bpa_pkg::OP_FIND: begin
        if (ans.found) finds_hit++;
        else finds_missed++;
      end
      bpa_pkg::OP_SET:   sets_done++;
      bpa_pkg::OP_CLEAR: clears_done++;
      default:           unused_done++;
    endcase
  endtask

  task automatic settle();
    if (req_ch.valid) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bpa_pkg::CFG_W-1:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.bytes_in_use <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    scan_limit = value;
    limit_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [bpa_pkg::CFG_W-1:0] limit, input int words);
    int win_pages;
    int lo;
    int hi;
    int pick;
    logic [bpa_pkg::OP_W-1:0]   op;
    logic [bpa_pkg::PAGE_W-1:0] page;
    write_limit(limit);
    win_pages = (limit == 0) ? 8 :
                ((limit > bpa_pkg::BITMAP_BYTES) ? 4096 : int'(limit) * 8);
    lo = (win_pages >= 16) ? win_pages - 8 : 0;
    hi = (win_pages + 15 > 4095) ? 4095 : win_pages + 15;
    for (int n = 0; n < words; n++) begin
      pick = $urandom_range(99);
      if (last_answer.found && pick < 60) begin
        // allocate what the last find returned
        op = bpa_pkg::OP_SET;
        page = last_answer.free_page;
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) op = bpa_pkg::OP_FIND;
        else if (pick < 68) op = bpa_pkg::OP_SET;
        else if (pick < 92) op = bpa_pkg::OP_CLEAR;
        else op = OP_UNUSED;
        pick = $urandom_range(99);
        if (pick < 75) page = bpa_pkg::PAGE_W'($urandom_range(win_pages - 1));
        else if (pick < 90) page = bpa_pkg::PAGE_W'($urandom_range(hi, lo));
        else page = bpa_pkg::PAGE_W'($urandom_range(4095));
      end
      send_word(op, page, 1'b0, '0);
    end
  endtask

  initial begin
    page_answer_t typed_ans;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= bpa_pkg::OP_FIND;
    req_ch.page_number <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.bytes_in_use <= '0;
    for (int i = 0; i < int'(bpa_pkg::BITMAP_BYTES); i++) page_map[i] = bpa_pkg::BYTE_EMPTY;
    scan_hint = '0;
    scan_limit = '0;
    last_answer = '0;
    mismatches = 0;
    finds_hit = 0;
    finds_missed = 0;
    sets_done = 0;
    clears_done = 0;
    unused_done = 0;
    limit_writes = 0;
    req_idle_pct = 27;
    rsp_idle_pct = 81;

    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_LIMIT, bpa_pkg::OP_FIND, 12'd0, 10'd1, 1'b0, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b1, 1'b1,
                                   12'd0));
    for (int p = 0; p < 8; p++)
      directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_SET, bpa_pkg::PAGE_W'(p), 10'd0,
                                     1'b1, 1'b0, 12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, OP_UNUSED, 12'd4095, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_CLEAR, 12'd3, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b1, 1'b1,
                                   12'd3));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_SET, 12'd4095, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_CLEAR, 12'd4095, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_LIMIT, bpa_pkg::OP_FIND, 12'd0, 10'd1023, 1'b0, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b0, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_CLEAR, 12'd2048, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b0, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_CLEAR, 12'd0, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b0, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_LIMIT, bpa_pkg::OP_FIND, 12'd0, 10'd512, 1'b0, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_SET, 12'd1365, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_SET, 12'd2730, 10'd0, 1'b1, 1'b0,
                                   12'd0));
    directed_plan.push_back(mk_row(ROW_WORD, bpa_pkg::OP_FIND, 12'd0, 10'd0, 1'b0, 1'b0,
                                   12'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_LIMIT) begin
        write_limit(directed_plan[i].limit);
      end else begin
        typed_ans.found = directed_plan[i].found;
        typed_ans.free_page = directed_plan[i].free_page;
        send_word(directed_plan[i].op, directed_plan[i].page, directed_plan[i].typed,
                  typed_ans);
      end
    end

    // random phases, fast sender and slow receiver first
    run_phase(10'd4, 200);
    run_phase(10'd0, 40);
    run_phase(10'd16, 200);
    settle();
    req_idle_pct = 81;
    rsp_idle_pct = 27;
    run_phase(10'd1, 150);
    run_phase(10'd512, 100);
    run_phase(10'd64, 200);
    settle();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    run_phase(10'd1023, 60);
    run_phase(10'd8, 300);
    run_phase(10'd2, 100);

    settle();
    repeat (20) @(posedge clk);
    if (pending_answers.size() != 0)
      flag_mismatch("words never answered", pending_answers.size(), 0);
    $display("covered %0d finds (%0d hit, %0d missed), %0d sets, %0d clears, %0d unused ops",
             finds_hit + finds_missed, finds_hit, finds_missed, sets_done, clears_done,
             unused_done);
    $display("over %0d limit writes from 0 to 1023, %0d mismatches", limit_writes,
             mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
